// File: hdl/nspe_pkg.sv
// Shared constants for the N-step phase extractor: field widths, stage map,
// Q1.14 correlation coefficients and the CORDIC arctangent steps.
// No dependencies.
`default_nettype none

package nspe_pkg;

   // Field widths
   localparam int SAMPLE_W    = 16;
   localparam int MAX_SAMPLES = 8;
   localparam int MIN_SAMPLES = 3;
   localparam int REQ_DATA_W  = SAMPLE_W * MAX_SAMPLES;
   localparam int PHASE_W     = 15;
   localparam int AMP_W       = 17;
   localparam int BIAS_W      = 16;
   localparam int THR_W       = 16;
   localparam int RSP_DATA_W  = PHASE_W + AMP_W + BIAS_W;

   // Internal widths
   localparam int COEF_W       = 16;
   localparam int PROD_W       = 32;  // sample * coefficient, |p| < 2^30
   localparam int PART_W       = 33;  // sum of four products
   localparam int CORR_W       = 34;  // full correlation, Q.22
   localparam int CS_W         = 22;  // rounded correlation, Q.10
   localparam int SUM_W        = 19;  // sum of up to eight samples
   localparam int SQ_W         = 41;
   localparam int MAG2_W       = 42;
   localparam int ROOT_W       = MAG2_W / 2;
   localparam int REM_W        = ROOT_W + 2;
   localparam int CORDIC_W     = 32;
   localparam int ANG_W        = 20;  // Q.16 radians
   localparam int CORDIC_ITERS = 16;

   // Stage map, stage 1 is loaded from the input beat
   localparam int ST_PROD      = 1;
   localparam int ST_PART      = 2;
   localparam int ST_TOT       = 3;
   localparam int ST_ROUND     = 4;
   localparam int MAG_STAGES   = ROOT_W + 2;
   localparam int COR_STAGES   = CORDIC_ITERS + 2;
   localparam int ST_MAG_FIRST = ST_ROUND + 1;
   localparam int ST_MAG_LAST  = ST_MAG_FIRST + MAG_STAGES - 1;
   localparam int ST_COR_FIRST = ST_ROUND + 1;
   localparam int ST_COR_LAST  = ST_COR_FIRST + COR_STAGES - 1;
   localparam int ST_OUT       = ST_MAG_LAST + 1;
   localparam int NST          = ST_OUT;

   localparam logic [THR_W-1:0]          THR_RESET = 16'd2560;
   localparam logic [AMP_W-1:0]          AMP_MAX   = '1;
   localparam logic signed [ANG_W-1:0]   PI_Q16    = 20'sd205887;
   localparam logic signed [PHASE_W-1:0] PI_Q12    = 15'sd12868;

   // Rows are indexed by sample count minus three
   localparam logic signed [COEF_W-1:0] SIN_Q14 [0:5][0:7] = '{
      '{16'sd0, 16'sd14189, -16'sd14189, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd15582, 16'sd9630, -16'sd9630, -16'sd15582, 16'sd0, 16'sd0,
        16'sd0},
      '{16'sd0, 16'sd14189, 16'sd14189, 16'sd0, -16'sd14189, -16'sd14189, 16'sd0,
        16'sd0},
      '{16'sd0, 16'sd12810, 16'sd15973, 16'sd7109, -16'sd7109, -16'sd15973,
        -16'sd12810, 16'sd0},
      '{16'sd0, 16'sd11585, 16'sd16384, 16'sd11585, 16'sd0, -16'sd11585,
        -16'sd16384, -16'sd11585}
   };

   localparam logic signed [COEF_W-1:0] COS_Q14 [0:5][0:7] = '{
      '{16'sd16384, -16'sd8192, -16'sd8192, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd16384, 16'sd5063, -16'sd13255, -16'sd13255, 16'sd5063, 16'sd0, 16'sd0,
        16'sd0},
      '{16'sd16384, 16'sd8192, -16'sd8192, -16'sd16384, -16'sd8192, 16'sd8192,
        16'sd0, 16'sd0},
      '{16'sd16384, 16'sd10215, -16'sd3646, -16'sd14761, -16'sd14761, -16'sd3646,
        16'sd10215, 16'sd0},
      '{16'sd16384, 16'sd11585, 16'sd0, -16'sd11585, -16'sd16384, -16'sd11585,
        16'sd0, 16'sd11585}
   };

   localparam logic signed [ANG_W-1:0] ATAN_Q16 [0:CORDIC_ITERS-1] = '{
      20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
      20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
      20'sd8, 20'sd4, 20'sd2
   };

endpackage

`default_nettype wire

// File: hdl/n_step_phase_extractor_core.sv
// N-step phase extractor: bias, amplitude and wrapped phase of one pixel.
// One beat per cycle sustained while rsp_tready stays high.
// Depth is set by the 21-stage square root; the CORDIC runs beside it.
// Each stage moves when its successor frees up, so bubbles are squeezed out.
// Reset (synchronous): clears all stage valid bits, threshold back to 2560.
`default_nettype none

module n_step_phase_extractor_core #(
   parameter int SAMPLES = 8
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire [nspe_pkg::REQ_DATA_W-1:0]      req_tdata,  // sample_0 .. sample_7, 16b each
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [nspe_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // phase[14:0] amplitude[31:15]
                                                           // bias[47:32]
   output logic                                rsp_tuser,  // phase_valid
   input  wire                                 csr_we,
   input  wire [nspe_pkg::THR_W-1:0]           csr_wdata
);
   import nspe_pkg::*;

   localparam int N_EFF = (SAMPLES < MIN_SAMPLES) ? MIN_SAMPLES :
                          ((SAMPLES > MAX_SAMPLES) ? MAX_SAMPLES : SAMPLES);
   localparam int ROW   = N_EFF - MIN_SAMPLES;

   // Mean by reciprocal multiply; exact for dividends below 2^19
   localparam int BIAS_SHIFT = 24;
   localparam int BIAS_MW    = 23;
   localparam int BIAS_PW    = SUM_W + BIAS_MW;
   localparam logic [BIAS_MW-1:0] BIAS_MUL = BIAS_MW'((1 << BIAS_SHIFT) / N_EFF + 1);
   localparam logic [NST-1:0]     FULL     = '1;

   // Flow control
   logic [NST:1] vld_ff, vld_in;
   logic [NST:1] ld;

   logic [THR_W-1:0] thr_ff;

   // Stage 1
   logic [SAMPLE_W-1:0]      smp;
   logic signed [PROD_W-1:0] sx;
   logic signed [PROD_W-1:0] psin_in [0:MAX_SAMPLES-1];
   logic signed [PROD_W-1:0] pcos_in [0:MAX_SAMPLES-1];
   logic signed [PROD_W-1:0] psin_ff [0:MAX_SAMPLES-1];
   logic signed [PROD_W-1:0] pcos_ff [0:MAX_SAMPLES-1];
   logic [SUM_W-1:0]         ssum_in, ssum_ff;

   // Stage 2
   logic signed [PART_W-1:0] slo_ff, shi_ff, clo_ff, chi_ff;
   logic [SUM_W-1:0]         bdiv_ff;

   // Stage 3
   logic signed [CORR_W-1:0] stot_ff, ctot_ff;
   logic [BIAS_PW-1:0]       bprod_ff;

   // Stage 4
   logic signed [CS_W-1:0]   cs_ff, cc_ff;
   logic [BIAS_W-1:0]        bias_ff [ST_ROUND:ST_OUT-1];

   // Later stages
   logic [ROOT_W-1:0]         root;
   logic signed [PHASE_W-1:0] cor_phase;
   logic signed [PHASE_W-1:0] pdly_ff [ST_COR_LAST+1:ST_OUT-1];
   logic [ROOT_W:0]           amp_rnd;
   logic [ROOT_W-3:0]         amp_full;
   logic [AMP_W-1:0]          amp_in;

   // Output stage
   logic [PHASE_W-1:0] phase_o_ff;
   logic [AMP_W-1:0]   amp_o_ff;
   logic [BIAS_W-1:0]  bias_o_ff;
   logic               pv_o_ff;

   function automatic logic signed [PART_W-1:0] add4(
      input logic signed [PROD_W-1:0] a,
      input logic signed [PROD_W-1:0] b,
      input logic signed [PROD_W-1:0] c,
      input logic signed [PROD_W-1:0] d
   );
      return (PART_W'(a) + PART_W'(b)) + (PART_W'(c) + PART_W'(d));
   endfunction

   // Q.22 to Q.10, half away from zero
   function automatic logic signed [CS_W-1:0] round12(
      input logic signed [CORR_W-1:0] v
   );
      logic [CORR_W-1:0] t;
      t = v + (v[CORR_W-1] ? CORR_W'(2047) : CORR_W'(2048));
      return $signed(t[CS_W+11:12]);
   endfunction

   // A stage loads when any stage at or after it is empty, or the output drains
   always_comb begin
      for (int k = 1; k <= NST; k++) begin
         ld[k] = rsp_tready || ((vld_ff >> (k - 1)) != (FULL >> (k - 1)));
      end
      vld_in[1] = ld[1] ? req_tvalid : vld_ff[1];
      for (int k = 2; k <= NST; k++) begin
         vld_in[k] = ld[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         thr_ff <= THR_RESET;
      end else begin
         vld_ff <= vld_in;
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
      end
   end

   assign req_tready = ld[1];
   assign rsp_tvalid = vld_ff[NST];

   // Stage 1: constant-coefficient products and sample sum
   always_comb begin
      ssum_in = '0;
      smp     = '0;
      sx      = '0;
      for (int i = 0; i < MAX_SAMPLES; i++) begin
         smp = req_tdata[i*SAMPLE_W +: SAMPLE_W];
         sx  = PROD_W'($signed({1'b0, smp}));
         if (i < N_EFF) begin
            psin_in[i] = sx * PROD_W'(SIN_Q14[ROW][i]);
            pcos_in[i] = sx * PROD_W'(COS_Q14[ROW][i]);
            ssum_in    = ssum_in + SUM_W'(smp);
         end else begin
            psin_in[i] = '0;
            pcos_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[ST_PROD]) begin
         psin_ff <= psin_in;
         pcos_ff <= pcos_in;
         ssum_ff <= ssum_in;
      end
      if (ld[ST_PART]) begin
         slo_ff  <= add4(psin_ff[0], psin_ff[1], psin_ff[2], psin_ff[3]);
         shi_ff  <= add4(psin_ff[4], psin_ff[5], psin_ff[6], psin_ff[7]);
         clo_ff  <= add4(pcos_ff[0], pcos_ff[1], pcos_ff[2], pcos_ff[3]);
         chi_ff  <= add4(pcos_ff[4], pcos_ff[5], pcos_ff[6], pcos_ff[7]);
         bdiv_ff <= ssum_ff + SUM_W'(N_EFF / 2);
      end
      if (ld[ST_TOT]) begin
         stot_ff  <= CORR_W'(slo_ff) + CORR_W'(shi_ff);
         ctot_ff  <= CORR_W'(clo_ff) + CORR_W'(chi_ff);
         bprod_ff <= BIAS_PW'(bdiv_ff) * BIAS_PW'(BIAS_MUL);
      end
      if (ld[ST_ROUND]) begin
         cs_ff             <= round12(stot_ff);
         cc_ff             <= round12(ctot_ff);
         bias_ff[ST_ROUND] <= bprod_ff[BIAS_SHIFT +: BIAS_W];
      end
      for (int k = ST_ROUND + 1; k < ST_OUT; k++) begin
         if (ld[k]) begin
            bias_ff[k] <= bias_ff[k-1];
         end
      end
      if (ld[ST_COR_LAST+1]) begin
         pdly_ff[ST_COR_LAST+1] <= cor_phase;
      end
      for (int k = ST_COR_LAST + 2; k < ST_OUT; k++) begin
         if (ld[k]) begin
            pdly_ff[k] <= pdly_ff[k-1];
         end
      end
   end

   nspe_mag u_mag (
      .clock (clock),
      .ld    (ld[ST_MAG_LAST:ST_MAG_FIRST]),
      .cs    (cs_ff),
      .cc    (cc_ff),
      .root  (root)
   );

   nspe_cordic u_cordic (
      .clock (clock),
      .ld    (ld[ST_COR_LAST:ST_COR_FIRST]),
      .x_in  (cs_ff),
      .y_in  (cc_ff),
      .phase (cor_phase)
   );

   // Amplitude: (root + 4) >> 3, saturated
   always_comb begin
      amp_rnd  = (ROOT_W+1)'(root) + (ROOT_W+1)'(4);
      amp_full = amp_rnd[ROOT_W:3];
      amp_in   = (amp_full > (ROOT_W-2)'(AMP_MAX)) ? AMP_MAX : AMP_W'(amp_full);
   end

   always_ff @(posedge clock) begin
      if (ld[ST_OUT]) begin
         phase_o_ff <= pdly_ff[ST_OUT-1];
         amp_o_ff   <= amp_in;
         bias_o_ff  <= bias_ff[ST_OUT-1];
         pv_o_ff    <= (amp_in >= AMP_W'(thr_ff));
      end
   end

   assign rsp_tdata = {bias_o_ff, amp_o_ff, phase_o_ff};
   assign rsp_tuser = pv_o_ff;

endmodule

`default_nettype wire

// File: hdl/nspe_mag.sv
// Magnitude pipeline: squares the rounded correlations, adds them and takes
// the floor square root one result bit per stage. Depends on nspe_pkg.
`default_nettype none

module nspe_mag (
   input  wire                                  clock,
   input  wire [nspe_pkg::MAG_STAGES-1:0]       ld,
   input  wire signed [nspe_pkg::CS_W-1:0]      cs,
   input  wire signed [nspe_pkg::CS_W-1:0]      cc,
   output logic [nspe_pkg::ROOT_W-1:0]          root
);
   import nspe_pkg::*;

   logic signed [2*CS_W-1:0] sqs_full, sqc_full;
   logic [SQ_W-1:0]          sqs_ff, sqc_ff;
   logic [MAG2_W-1:0]        mag2_ff;
   logic [REM_W-1:0]         rem_ff  [1:ROOT_W-1];
   logic [ROOT_W-1:0]        root_ff [1:ROOT_W];
   logic [MAG2_W-1:0]        rad_ff  [1:ROOT_W-1];

   always_comb begin
      sqs_full = cs * cs;
      sqc_full = cc * cc;
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         sqs_ff <= SQ_W'(sqs_full);
         sqc_ff <= SQ_W'(sqc_full);
      end
      if (ld[1]) begin
         mag2_ff <= MAG2_W'(sqs_ff) + MAG2_W'(sqc_ff);
      end
   end

   // Digit j decides root bit ROOT_W-j from the next two radicand bits
   for (genvar j = 1; j <= ROOT_W; j++) begin : g_dig
      logic [REM_W-1:0]  r_prev;
      logic [ROOT_W-1:0] q_prev;
      logic [MAG2_W-1:0] d_prev;
      logic [REM_W+1:0]  trial, tval;
      logic              take;

      if (j == 1) begin : g_first
         assign r_prev = '0;
         assign q_prev = '0;
         assign d_prev = mag2_ff;
      end else begin : g_next
         assign r_prev = rem_ff[j-1];
         assign q_prev = root_ff[j-1];
         assign d_prev = rad_ff[j-1];
      end

      always_comb begin
         trial = {r_prev, d_prev[MAG2_W-1 -: 2]};
         tval  = (REM_W+2)'({q_prev, 2'b01});
         take  = (trial >= tval);
      end

      always_ff @(posedge clock) begin
         if (ld[j+1]) begin
            root_ff[j] <= {q_prev[ROOT_W-2:0], take};
         end
      end

      if (j < ROOT_W) begin : g_carry
         always_ff @(posedge clock) begin
            if (ld[j+1]) begin
               rem_ff[j] <= take ? REM_W'(trial - tval) : REM_W'(trial);
               rad_ff[j] <= {d_prev[MAG2_W-3:0], 2'b00};
            end
         end
      end
   end

   assign root = root_ff[ROOT_W];

endmodule

`default_nettype wire

// File: hdl/nspe_cordic.sv
// Vectoring CORDIC for atan2(y, x): quadrant fold, one rotation per stage,
// then rounding to Q3.12 with clamp to +-pi. Depends on nspe_pkg.
`default_nettype none

module nspe_cordic (
   input  wire                                  clock,
   input  wire [nspe_pkg::COR_STAGES-1:0]       ld,
   input  wire signed [nspe_pkg::CS_W-1:0]      x_in,
   input  wire signed [nspe_pkg::CS_W-1:0]      y_in,
   output logic signed [nspe_pkg::PHASE_W-1:0]  phase
);
   import nspe_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff   [0:CORDIC_ITERS-1];
   logic signed [CORDIC_W-1:0] y_ff   [0:CORDIC_ITERS-1];
   logic signed [ANG_W-1:0]    ang_ff [0:CORDIC_ITERS];
   logic                       zero_ff[0:CORDIC_ITERS];
   logic signed [PHASE_W-1:0]  phase_ff;

   logic signed [CORDIC_W-1:0] xe, ye;
   logic signed [ANG_W-1:0]    ang0;
   logic signed [ANG_W-1:0]    ang_rnd;
   logic signed [ANG_W-5:0]    ang_q12;
   logic signed [PHASE_W-1:0]  phase_in;

   // Left half plane folds to the right with a +-pi start angle
   always_comb begin
      xe   = CORDIC_W'(x_in);
      ye   = CORDIC_W'(y_in);
      ang0 = '0;
      if (x_in < 0) begin
         ang0 = y_in[CS_W-1] ? -PI_Q16 : PI_Q16;
         xe   = -xe;
         ye   = -ye;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         x_ff[0]    <= xe <<< 8;
         y_ff[0]    <= ye <<< 8;
         ang_ff[0]  <= ang0;
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
      end
   end

   for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
      always_ff @(posedge clock) begin
         if (ld[i+1]) begin
            zero_ff[i+1] <= zero_ff[i];
            ang_ff[i+1]  <= y_ff[i][CORDIC_W-1] ? ang_ff[i] - ATAN_Q16[i]
                                                : ang_ff[i] + ATAN_Q16[i];
         end
      end

      if (i < CORDIC_ITERS - 1) begin : g_xy
         logic signed [CORDIC_W-1:0] xs, ys;

         always_comb begin
            xs = x_ff[i] >>> i;
            ys = y_ff[i] >>> i;
         end

         always_ff @(posedge clock) begin
            if (ld[i+1]) begin
               if (!y_ff[i][CORDIC_W-1]) begin
                  x_ff[i+1] <= x_ff[i] + ys;
                  y_ff[i+1] <= y_ff[i] - xs;
               end else begin
                  x_ff[i+1] <= x_ff[i] - ys;
                  y_ff[i+1] <= y_ff[i] + xs;
               end
            end
         end
      end
   end

   // Round half away from zero from Q.16 to Q.12
   always_comb begin
      ang_rnd = ang_ff[CORDIC_ITERS]
              + (ang_ff[CORDIC_ITERS][ANG_W-1] ? ANG_W'(7) : ANG_W'(8));
      ang_q12 = $signed(ang_rnd[ANG_W-1:4]);
      if (zero_ff[CORDIC_ITERS]) begin
         phase_in = '0;
      end else if (ang_q12 > PI_Q12) begin
         phase_in = PI_Q12;
      end else if (ang_q12 < -PI_Q12) begin
         phase_in = -PI_Q12;
      end else begin
         phase_in = PHASE_W'(ang_q12);
      end
   end

   always_ff @(posedge clock) begin
      if (ld[CORDIC_ITERS+1]) begin
         phase_ff <= phase_in;
      end
   end

   assign phase = phase_ff;

endmodule

`default_nettype wire

// File: hdl/nspe_checker.sv
// Port-level checks for n_step_phase_extractor_core, attached by bind.
// Depends on nspe_pkg for the pipeline depth.
`default_nettype none

module nspe_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 req_tvalid,
   input wire                                 req_tready,
   input wire                                 rsp_tvalid,
   input wire                                 rsp_tready,
   input wire [nspe_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input wire                                 rsp_tuser
);
   import nspe_pkg::*;

   localparam int CNT_W = $clog2(NST + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             in_beat, out_beat;

   // Beats inside the pipeline
   always_comb begin
      in_beat  = req_tvalid && req_tready;
      out_beat = rsp_tvalid && rsp_tready;
      cnt_in   = cnt_ff + CNT_W'(in_beat) - CNT_W'(out_beat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat offered right after reset");

   a_no_invented : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (cnt_ff != '0))
      else $error("result beat without a pending input beat");

   a_depth : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(NST))
      else $error("more beats in flight than pipeline stages");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result beat changed");

endmodule

bind n_step_phase_extractor_core nspe_checker u_nspe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// File: test/n_step_phase_extractor_core_tb.sv
// Testbench for n_step_phase_extractor_core: directed and random pixels through
// the req/rsp streams, checked against typed results or an in-bench fixed-point predictor.
// Depends on nspe_pkg and the core RTL only.
`timescale 1ns / 1ps

module n_step_phase_extractor_core_tb;
   import nspe_pkg::*;

   typedef logic [MAX_SAMPLES-1:0][SAMPLE_W-1:0] pixel_samples_type;

   typedef struct packed {
      logic signed [PHASE_W-1:0] phase;
      logic [AMP_W-1:0]          amplitude;
      logic [BIAS_W-1:0]         bias;
      logic                      phase_valid;
   } pixel_result_type;

   typedef struct packed {
      pixel_samples_type smp;
      logic              typed;  // res holds the hand-written result
      pixel_result_type  res;
   } stim_row_type;

   typedef enum int unsigned {MIX_UNIFORM, MIX_NEAR_FLAT, MIX_CORNERS} pixel_mix_type;

   localparam int NUM_DIR        = 19;
   localparam int NUM_PHASES     = 8;
   localparam int PHASE_ITEMS    = 130;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 40;   // pipeline is 28 deep
   localparam int WATCHDOG_LIMIT = 2000;

   // Eight-step correlation in Q1.14, atan steps in Q.16
   localparam int SIN_COEF [8] = '{0, 11585, 16384, 11585, 0, -11585, -16384, -11585};
   localparam int COS_COEF [8] = '{16384, 11585, 0, -11585, -16384, -11585, 0, 11585};
   localparam int ARCTAN_STEP [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                       256, 128, 64, 32, 16, 8, 4, 2};
   localparam longint HALF_TURN_Q16 = 205887;
   localparam longint HALF_TURN_Q12 = 12868;
   localparam longint AMP_SAT       = 131071;
   localparam pixel_result_type UNTYPED = '0;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // sample_0 .. sample_7, 16 bits each
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // phase, amplitude, bias
   logic                  rsp_tuser;        // phase_valid
   logic                  csr_we = 1'b0;
   logic [THR_W-1:0]      csr_wdata = '0;

   pixel_result_type  pending_pixels [$];
   stim_row_type      dir_table [NUM_DIR];
   logic [THR_W-1:0] threshold = THR_RESET;
   int unsigned    tx_max_gap = 18;
   int unsigned    rx_max_stall = 18;
   bit             hold_output = 1'b0;
   int             mismatch_count = 0;
   int             idle_cycles = 0;

   n_step_phase_extractor_core #(.SAMPLES(8)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic longint round_shift(longint v, int unsigned sh);
      longint h;
      h = longint'(1) << (sh - 1);
      return (v >= 0) ? ((v + h) >>> sh) : -((-v + h) >>> sh);
   endfunction

   function automatic longint floor_sqrt(longint v);
      longint r, b;
      r = 0;
      for (int k = 21; k >= 0; k--) begin
         b = r | (longint'(1) << k);
         if (b * b <= v) r = b;
      end
      return r;
   endfunction

   // vectoring CORDIC, angle of (x, y) in Q3.12
   function automatic longint cordic_phase(longint y, longint x);
      longint ang, xs, ys;
      ang = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         ang = (y >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
         x = -x;
         y = -y;
      end
      x = x * 256;
      y = y * 256;
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            ang = ang + ARCTAN_STEP[i];
         end else begin
            x = x - ys;
            y = y + xs;
            ang = ang - ARCTAN_STEP[i];
         end
      end
      ang = round_shift(ang, 4);
      if (ang > HALF_TURN_Q12) ang = HALF_TURN_Q12;
      if (ang < -HALF_TURN_Q12) ang = -HALF_TURN_Q12;
      return ang;
   endfunction

   function automatic pixel_result_type extract_phase(pixel_samples_type s,
                                                      logic [THR_W-1:0] thr);
      longint corr_s, corr_c, total, amp, ang;
      pixel_result_type r;
      corr_s = 0;
      corr_c = 0;
      total = 0;
      for (int i = 0; i < 8; i++) begin
         total  = total + longint'(s[i]);
         corr_s = corr_s + longint'(s[i]) * SIN_COEF[i];
         corr_c = corr_c + longint'(s[i]) * COS_COEF[i];
      end
      corr_s = round_shift(corr_s, 12);
      corr_c = round_shift(corr_c, 12);
      amp = (floor_sqrt(corr_s * corr_s + corr_c * corr_c) + 4) >>> 3;
      if (amp > AMP_SAT) amp = AMP_SAT;
      ang = cordic_phase(corr_c, corr_s);
      r.phase       = ang[PHASE_W-1:0];
      r.amplitude   = amp[AMP_W-1:0];
      r.bias        = BIAS_W'((total + 4) / 8);
      r.phase_valid = (amp >= longint'(thr));
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic pixel_samples_type pack_samples(
      logic [15:0] a0, logic [15:0] a1, logic [15:0] a2, logic [15:0] a3,
      logic [15:0] a4, logic [15:0] a5, logic [15:0] a6, logic [15:0] a7);
      pixel_samples_type s;
      s[0] = a0; s[1] = a1; s[2] = a2; s[3] = a3;
      s[4] = a4; s[5] = a5; s[6] = a6; s[7] = a7;
      return s;
   endfunction

   function automatic pixel_samples_type make_pixel(pixel_mix_type mix);
      pixel_samples_type s;
      logic [15:0] base, mask;
      base = 16'($urandom);
      mask = 16'((32'd1 << $urandom_range(0, 12)) - 1);
      for (int i = 0; i < 8; i++) begin
         case (mix)
            MIX_UNIFORM:   s[i] = 16'($urandom);
            MIX_NEAR_FLAT: s[i] = base ^ (16'($urandom) & mask);  // small amplitude
            default:       s[i] = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
         endcase
      end
      return s;
   endfunction

   task automatic send_pixel(pixel_samples_type s, logic typed,
                             pixel_result_type typed_res);
      int unsigned gap;
      gap = $urandom_range(0, tx_max_gap);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      pending_pixels.insert(pending_pixels.size(),
                            typed ? typed_res : extract_phase(s, threshold));
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_threshold(logic [THR_W-1:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      threshold = v;
   endtask

   initial begin
      pixel_samples_type probe;
      pixel_result_type  probe_res;
      logic [THR_W-1:0] thr;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      dir_table = '{
         '{pack_samples(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{15'sd0, 17'd0, 16'd0, 1'b0}},
         '{pack_samples(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 16'hFFFF), 1'b1, '{15'sd0, 17'd0, 16'hFFFF, 1'b0}},
         '{pack_samples(1, 1, 1, 1, 1, 1, 1, 1), 1'b1, '{15'sd0, 17'd0, 16'd1, 1'b0}},
         '{pack_samples(16'hFFFF, 0, 0, 0, 0, 0, 0, 0), 1'b0, UNTYPED},
         '{pack_samples(0, 16'hFFFF, 0, 0, 0, 0, 0, 0), 1'b0, UNTYPED},
         '{pack_samples(0, 0, 16'hFFFF, 0, 0, 0, 0, 0), 1'b0, UNTYPED},
         '{pack_samples(0, 0, 0, 16'hFFFF, 0, 0, 0, 0), 1'b0, UNTYPED},
         '{pack_samples(0, 0, 0, 0, 16'hFFFF, 0, 0, 0), 1'b0, UNTYPED},
         '{pack_samples(0, 0, 0, 0, 0, 16'hFFFF, 0, 0), 1'b0, UNTYPED},
         '{pack_samples(0, 0, 0, 0, 0, 0, 16'hFFFF, 0), 1'b0, UNTYPED},
         '{pack_samples(0, 0, 0, 0, 0, 0, 0, 16'hFFFF), 1'b0, UNTYPED},
         // phase right at +pi and just past -pi, clamped
         '{pack_samples(0, 0, 0, 0, 0, 0, 16'hFFFF, 1), 1'b0, UNTYPED},
         '{pack_samples(0, 0, 0, 1, 0, 0, 16'hFFFF, 0), 1'b0, UNTYPED},
         '{pack_samples(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                        16'hAAAA, 16'h5555), 1'b0, UNTYPED},
         '{pack_samples(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0), 1'b0, UNTYPED},
         '{pack_samples(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0), 1'b0, UNTYPED},
         '{pack_samples(16'h0A01, 16'h0A00, 16'h0A00, 16'h0A00, 16'h0A00, 16'h0A00,
                        16'h0A00, 16'h0A00), 1'b0, UNTYPED},
         '{pack_samples(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
                        16'h8000, 16'h8000), 1'b0, UNTYPED},
         '{pack_samples(16'h00FF, 16'hFF00, 16'h00FF, 16'hFF00, 16'h00FF, 16'hFF00,
                        16'h00FF, 16'hFF00), 1'b0, UNTYPED}
      };

      // directed rows run at the reset threshold
      foreach (dir_table[i]) send_pixel(dir_table[i].smp, dir_table[i].typed, dir_table[i].res);

      probe = make_pixel(MIX_NEAR_FLAT);
      probe_res = extract_phase(probe, '0);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drain();
         case (ph)
            0: thr = '0;
            1: thr = '1;
            2: thr = 16'd1;
            4: thr = probe_res.amplitude[THR_W-1:0];           // probe lands exactly on it
            5: thr = probe_res.amplitude[THR_W-1:0] + 16'd1;   // probe just misses
            7: thr = 16'($urandom_range(0, 4096));
            default: thr = 16'($urandom);
         endcase
         write_threshold(thr);
         tx_max_gap   = (ph % 2 == 0) ? 18 : 0;
         rx_max_stall = (ph % 4 == 0 || ph % 4 == 3) ? 18 : 0;
         if (ph == 6) begin
            // back up the pipe: receiver stalls while beats keep coming
            tx_max_gap = 0;
            hold_output = 1'b1;
         end
         if (ph == 4 || ph == 5) send_pixel(probe, 1'b0, UNTYPED);
         repeat (PHASE_ITEMS)
            send_pixel(make_pixel(pixel_mix_type'($urandom_range(0, 2))), 1'b0, UNTYPED);
      end

      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   initial begin
      int unsigned stall;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_output) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_output = 1'b0;
         end
         stall = $urandom_range(0, rx_max_stall);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // ---------------------------------------------------------------- checker

   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            $error("rsp beat with nothing expected: tdata %h tuser %b", rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_tdata[PHASE_W-1:0] !== want.phase) begin
               $error("phase: expected %0d, got %0d", want.phase,
                      $signed(rsp_tdata[PHASE_W-1:0]));
               mismatch_count++;
            end
            if (rsp_tdata[PHASE_W+AMP_W-1:PHASE_W] !== want.amplitude) begin
               $error("amplitude: expected %0d, got %0d", want.amplitude,
                      rsp_tdata[PHASE_W+AMP_W-1:PHASE_W]);
               mismatch_count++;
            end
            if (rsp_tdata[RSP_DATA_W-1:PHASE_W+AMP_W] !== want.bias) begin
               $error("bias: expected %0d, got %0d", want.bias,
                      rsp_tdata[RSP_DATA_W-1:PHASE_W+AMP_W]);
               mismatch_count++;
            end
            if (rsp_tuser !== want.phase_valid) begin
               $error("phase_valid: expected %0d, got %0d", want.phase_valid, rsp_tuser);
               mismatch_count++;
            end
         end
      end
   end

   // stretch without any beat on either side; longest legal one is the hold-off
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

endmodule
